// ===== sv/sfl_pkg.sv =====
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants for the serial flash link recovery controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sfl_pkg;

   // largest read a single request may ask for
   localparam int MAX_READ = 256;

   // command bytes
   localparam logic [7:0] OP_READ_ID = 8'h9F;
   localparam logic [7:0] OP_READ    = 8'h03;

   // receive length of the id transfer (opcode echo plus three id bytes)
   localparam logic [8:0] ID_RX_LEN  = 9'd4;
   // bytes clocked in ahead of read data
   localparam logic [8:0] RD_RX_EXTRA = 9'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_WAIT_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] CSR_EXPECTED_ID = 2'd2;
   localparam logic [1:0] CSR_FLASH_BYTES = 2'd3;

   // configuration reset values
   localparam logic [7:0]  WAIT_LIMIT_RST  = 8'd200;
   localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;
   localparam logic [23:0] EXPECTED_ID_RST = 24'h016017;
   localparam logic [24:0] FLASH_BYTES_RST = 25'd16777216;

   // link modes
   typedef enum logic [2:0] {
      MODE_READY    = 3'd0,
      MODE_UNINIT   = 3'd1,
      MODE_INIT     = 3'd2,
      MODE_BUSY     = 3'd3,
      MODE_COMM_ERR = 3'd4,
      MODE_DEV_ERR  = 3'd5
   } mode_type;

   // reply code beyond the mode codes
   localparam logic [2:0] REPLY_PARAM_ERR = 3'd6;

   // request actions
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic [7:0]  wait_limit;
      logic [7:0]  retry_limit;
      logic [23:0] expected_id;
      logic [24:0] flash_bytes;
   } cfg_type;

   typedef struct packed {
      logic        action;
      logic        xfer_done;
      logic        cs_granted;
      logic [23:0] id_bytes;
      logic [23:0] address;
      logic [15:0] byte_count;
   } item_type;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  reply;
      logic        start_transfer;
      logic [7:0]  opcode;
      logic [23:0] xfer_address;
      logic [8:0]  rx_length;
      logic        release_select;
      logic        reset_pin;
      logic        activity_led;
      logic        read_done;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/sfl_csr.sv =====
// ----------------------------------------------------------------------------
// sfl_csr
// Configuration registers of the flash link controller, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [24:0]     csr_wdata,
   output sfl_pkg::cfg_type     cfg
);

   sfl_pkg::cfg_type cfg_ff;
   sfl_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sfl_pkg::CSR_WAIT_LIMIT:  cfg_in.wait_limit  = csr_wdata[7:0];
            sfl_pkg::CSR_RETRY_LIMIT: cfg_in.retry_limit = csr_wdata[7:0];
            sfl_pkg::CSR_EXPECTED_ID: cfg_in.expected_id = csr_wdata[23:0];
            sfl_pkg::CSR_FLASH_BYTES: cfg_in.flash_bytes = csr_wdata[24:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_limit  <= sfl_pkg::WAIT_LIMIT_RST;
         cfg_ff.retry_limit <= sfl_pkg::RETRY_LIMIT_RST;
         cfg_ff.expected_id <= sfl_pkg::EXPECTED_ID_RST;
         cfg_ff.flash_bytes <= sfl_pkg::FLASH_BYTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/sfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfl_ctrl
// Link state machine: mode, wait and retry counters, pin levels, and the
// combinational result of one item against the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire sfl_pkg::item_type item,
   input  wire sfl_pkg::cfg_type cfg,
   output sfl_pkg::result_type   res
);

   sfl_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        wait_count_ff, wait_count_in;
   logic [7:0]        retry_count_ff, retry_count_in;
   logic              reset_level_ff, reset_level_in;
   logic              led_level_ff, led_level_in;

   logic              wait_expired;
   logic              read_ok;
   logic [24:0]       read_end;
   logic [7:0]        wait_preset;

   // read range check and timeout preset
   assign read_end     = {1'b0, item.address} + {9'd0, item.byte_count};
   assign read_ok      = (read_end < cfg.flash_bytes) && (item.byte_count != 16'd0) &&
                         (item.byte_count <= 16'(sfl_pkg::MAX_READ));
   assign wait_expired = wait_count_ff >= cfg.wait_limit;
   assign wait_preset  = (cfg.wait_limit == 8'd0) ? 8'd0 : cfg.wait_limit - 8'd1;

   // next state and result
   always_comb begin
      mode_in        = mode_ff;
      wait_count_in  = wait_count_ff;
      retry_count_in = retry_count_ff;
      reset_level_in = reset_level_ff;
      led_level_in   = led_level_ff;
      res            = '0;

      if (item.action == sfl_pkg::ACT_TICK) begin
         case (mode_ff)
            sfl_pkg::MODE_UNINIT: begin
               reset_level_in = 1'b1;
               led_level_in   = 1'b1;
               if (item.cs_granted) begin
                  res.start_transfer = 1'b1;
                  res.opcode         = sfl_pkg::OP_READ_ID;
                  res.rx_length      = sfl_pkg::ID_RX_LEN;
                  mode_in            = sfl_pkg::MODE_INIT;
                  wait_count_in      = 8'd0;
               end else begin
                  mode_in = sfl_pkg::MODE_COMM_ERR;
               end
            end
            sfl_pkg::MODE_INIT: begin
               if (item.xfer_done) begin
                  res.release_select = 1'b1;
                  if (item.id_bytes == cfg.expected_id) begin
                     mode_in      = sfl_pkg::MODE_READY;
                     led_level_in = 1'b0;
                  end else begin
                     mode_in = sfl_pkg::MODE_COMM_ERR;
                  end
               end else if (wait_expired) begin
                  res.release_select = 1'b1;
                  mode_in            = sfl_pkg::MODE_COMM_ERR;
               end else begin
                  wait_count_in = wait_count_ff + 8'd1;
               end
            end
            sfl_pkg::MODE_BUSY: begin
               if (item.xfer_done) begin
                  res.release_select = 1'b1;
                  res.read_done      = 1'b1;
                  mode_in            = sfl_pkg::MODE_READY;
                  led_level_in       = 1'b0;
               end else if (wait_expired) begin
                  res.release_select = 1'b1;
                  mode_in            = sfl_pkg::MODE_COMM_ERR;
               end else begin
                  wait_count_in = wait_count_ff + 8'd1;
               end
            end
            sfl_pkg::MODE_COMM_ERR: begin
               if (retry_count_ff < cfg.retry_limit) begin
                  if (wait_expired) begin
                     reset_level_in = 1'b0;
                     retry_count_in = retry_count_ff + 8'd1;
                     mode_in        = sfl_pkg::MODE_UNINIT;
                     wait_count_in  = 8'd0;
                  end else begin
                     wait_count_in = wait_count_ff + 8'd1;
                  end
               end else begin
                  mode_in = sfl_pkg::MODE_DEV_ERR;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
         res.reply = mode_in;
      end else begin
         res.reply = mode_ff;
         if (mode_ff == sfl_pkg::MODE_READY) begin
            if (read_ok) begin
               led_level_in = 1'b1;
               if (item.cs_granted) begin
                  res.start_transfer = 1'b1;
                  res.opcode         = sfl_pkg::OP_READ;
                  res.xfer_address   = item.address;
                  res.rx_length      = item.byte_count[8:0] + sfl_pkg::RD_RX_EXTRA;
                  wait_count_in      = wait_preset;
                  mode_in            = sfl_pkg::MODE_BUSY;
               end else begin
                  mode_in   = sfl_pkg::MODE_COMM_ERR;
                  res.reply = sfl_pkg::MODE_COMM_ERR;
               end
            end else begin
               res.reply = sfl_pkg::REPLY_PARAM_ERR;
            end
         end
      end

      res.mode         = mode_in;
      res.reset_pin    = reset_level_in;
      res.activity_led = led_level_in;
   end

   // state registers, updated once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= sfl_pkg::MODE_UNINIT;
         wait_count_ff  <= 8'd0;
         retry_count_ff <= 8'd0;
         reset_level_ff <= 1'b0;
         led_level_ff   <= 1'b0;
      end else if (step) begin
         mode_ff        <= mode_in;
         wait_count_ff  <= wait_count_in;
         retry_count_ff <= retry_count_in;
         reset_level_ff <= reset_level_in;
         led_level_ff   <= led_level_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/spi_flash_link_recovery_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// spi_flash_link_recovery_fsm_unit
// Serial flash link recovery controller: id check, timeouts, retries and
// range-checked read command issue.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   req_*     in          req_valid / req_ready  action, xfer_done, cs_granted,
//                                                id_bytes, address, byte_count
//   rsp_*     out         rsp_valid / rsp_ready  mode, reply, command, pins
//   csr_*     in          csr_we                 csr_index, csr_wdata
//
// An item is captured in the input register, evaluated against the link
// state combinationally and lands in the result register, which raises
// rsp_valid; one item per cycle is sustained while rsp_ready stays high.
// Synchronous reset returns the configuration to defaults and the link to
// uninitialized; both registers come up empty.
// A stalled rsp_ready holds the result; the input register still takes one
// more item, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_flash_link_recovery_fsm_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output wire logic        req_ready,
   input  wire logic        req_action,
   input  wire logic        req_xfer_done,
   input  wire logic        req_cs_granted,
   input  wire logic [23:0] req_id_bytes,
   input  wire logic [23:0] req_address,
   input  wire logic [15:0] req_byte_count,
   // result items
   output wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   output wire logic [2:0]  rsp_mode,
   output wire logic [2:0]  rsp_reply,
   output wire logic        rsp_start_transfer,
   output wire logic [7:0]  rsp_opcode,
   output wire logic [23:0] rsp_xfer_address,
   output wire logic [8:0]  rsp_rx_length,
   output wire logic        rsp_release_select,
   output wire logic        rsp_reset_pin,
   output wire logic        rsp_activity_led,
   output wire logic        rsp_read_done,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [24:0] csr_wdata
);

   sfl_pkg::cfg_type    cfg;
   sfl_pkg::item_type   item_ff;
   sfl_pkg::result_type res;
   sfl_pkg::result_type rsp_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                step;
   logic                req_fire;

   // pipeline control
   assign step      = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   sfl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.action     <= req_action;
         item_ff.xfer_done  <= req_xfer_done;
         item_ff.cs_granted <= req_cs_granted;
         item_ff.id_bytes   <= req_id_bytes;
         item_ff.address    <= req_address;
         item_ff.byte_count <= req_byte_count;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = rsp_ff.mode;
   assign rsp_reply          = rsp_ff.reply;
   assign rsp_start_transfer = rsp_ff.start_transfer;
   assign rsp_opcode         = rsp_ff.opcode;
   assign rsp_xfer_address   = rsp_ff.xfer_address;
   assign rsp_rx_length      = rsp_ff.rx_length;
   assign rsp_release_select = rsp_ff.release_select;
   assign rsp_reset_pin      = rsp_ff.reset_pin;
   assign rsp_activity_led   = rsp_ff.activity_led;
   assign rsp_read_done      = rsp_ff.read_done;

endmodule

`default_nettype wire

// ===== sv/sfl_checker.sv =====
// ----------------------------------------------------------------------------
// sfl_checker
// Port-level checks on the flash link controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_mode,
   input wire logic        rsp_start_transfer,
   input wire logic [7:0]  rsp_opcode,
   input wire logic [23:0] rsp_xfer_address,
   input wire logic [8:0]  rsp_rx_length,
   input wire logic        rsp_release_select,
   input wire logic        rsp_read_done
);

   // a result under stall stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // an issued transfer carries one of the two commands
   a_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_transfer |->
         (rsp_opcode == sfl_pkg::OP_READ_ID) || (rsp_opcode == sfl_pkg::OP_READ))
      else $error("transfer issued with unknown command");

   // no transfer means no command fields
   a_idle_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_start_transfer |->
         (rsp_opcode == 8'd0) && (rsp_rx_length == 9'd0) && (rsp_xfer_address == 24'd0))
      else $error("command fields set without a transfer");

   // completed read releases select and leaves the link ready
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_done |->
         rsp_release_select && (rsp_mode == sfl_pkg::MODE_READY) && !rsp_start_transfer)
      else $error("read completion without release or ready mode");

endmodule

bind spi_flash_link_recovery_fsm_unit sfl_checker u_sfl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_mode           (rsp_mode),
   .rsp_start_transfer (rsp_start_transfer),
   .rsp_opcode         (rsp_opcode),
   .rsp_xfer_address   (rsp_xfer_address),
   .rsp_rx_length      (rsp_rx_length),
   .rsp_release_select (rsp_release_select),
   .rsp_read_done      (rsp_read_done)
);

`default_nettype wire

// ===== sim/tb_spi_flash_link_recovery_fsm_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_flash_link_recovery_fsm_unit
// Self-checking bench for the serial flash link recovery controller. A
// directed table walks bring-up, read range checks, stalls, timeouts,
// retries and register extremes. Random phases with mostly well-formed
// traffic follow. Every result item is checked field by field against a
// link model kept inside the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_spi_flash_link_recovery_fsm_unit;

   typedef enum logic [1:0] { ROW_ITEM, ROW_CSR } row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type        kind;
      sfl_pkg::item_type   stim;
      logic                typed;
      sfl_pkg::result_type want;
      logic [1:0]          reg_index;
      logic [24:0]         reg_value;
   } plan_row_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic        req_action         = sfl_pkg::ACT_TICK;
   logic        req_xfer_done      = 1'b0;
   logic        req_cs_granted     = 1'b0;
   logic [23:0] req_id_bytes       = '0;
   logic [23:0] req_address        = '0;
   logic [15:0] req_byte_count     = '0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [2:0]  rsp_mode;
   logic [2:0]  rsp_reply;
   logic        rsp_start_transfer;
   logic [7:0]  rsp_opcode;
   logic [23:0] rsp_xfer_address;
   logic [8:0]  rsp_rx_length;
   logic        rsp_release_select;
   logic        rsp_reset_pin;
   logic        rsp_activity_led;
   logic        rsp_read_done;
   logic        csr_we             = 1'b0;
   logic [1:0]  csr_index          = sfl_pkg::CSR_WAIT_LIMIT;
   logic [24:0] csr_wdata          = '0;

   // link model state and its copy of the registers
   sfl_pkg::cfg_type  link_cfg;
   sfl_pkg::mode_type lnk_mode;
   logic [7:0]        wait_cnt;
   logic [7:0]        retry_cnt;
   logic              pin_run;
   logic              led_on;

   sfl_pkg::result_type due_results[$];
   int          error_count = 0;
   int          sent_count  = 0;
   int          seen_count  = 0;
   bit          burst_on    = 1'b0;
   bit          held_off    = 1'b0;

   spi_flash_link_recovery_fsm_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_xfer_done      (req_xfer_done),
      .req_cs_granted     (req_cs_granted),
      .req_id_bytes       (req_id_bytes),
      .req_address        (req_address),
      .req_byte_count     (req_byte_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mode           (rsp_mode),
      .rsp_reply          (rsp_reply),
      .rsp_start_transfer (rsp_start_transfer),
      .rsp_opcode         (rsp_opcode),
      .rsp_xfer_address   (rsp_xfer_address),
      .rsp_rx_length      (rsp_rx_length),
      .rsp_release_select (rsp_release_select),
      .rsp_reset_pin      (rsp_reset_pin),
      .rsp_activity_led   (rsp_activity_led),
      .rsp_read_done      (rsp_read_done),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stall count in initializing or busy; true when the wait has run out
   function automatic logic wait_expired();
      if (wait_cnt >= link_cfg.wait_limit) begin
         lnk_mode = sfl_pkg::MODE_COMM_ERR;
         return 1'b1;
      end
      wait_cnt = wait_cnt + 8'd1;
      return 1'b0;
   endfunction

   // advance the link model by one item and return its result
   function automatic sfl_pkg::result_type link_step(input sfl_pkg::item_type it);
      sfl_pkg::result_type r;
      logic [31:0] span;
      r = '0;
      if (it.action == sfl_pkg::ACT_TICK) begin
         case (lnk_mode)
            sfl_pkg::MODE_UNINIT: begin
               pin_run = 1'b1;
               led_on  = 1'b1;
               if (it.cs_granted) begin
                  r.start_transfer = 1'b1;
                  r.opcode         = sfl_pkg::OP_READ_ID;
                  r.rx_length      = sfl_pkg::ID_RX_LEN;
                  lnk_mode         = sfl_pkg::MODE_INIT;
                  wait_cnt         = 8'd0;
               end else begin
                  lnk_mode = sfl_pkg::MODE_COMM_ERR;
               end
            end
            sfl_pkg::MODE_INIT: begin
               if (it.xfer_done) begin
                  r.release_select = 1'b1;
                  if (it.id_bytes == link_cfg.expected_id) begin
                     lnk_mode = sfl_pkg::MODE_READY;
                     led_on   = 1'b0;
                  end else begin
                     lnk_mode = sfl_pkg::MODE_COMM_ERR;
                  end
               end else begin
                  r.release_select = wait_expired();
               end
            end
            sfl_pkg::MODE_BUSY: begin
               if (it.xfer_done) begin
                  r.release_select = 1'b1;
                  r.read_done      = 1'b1;
                  lnk_mode         = sfl_pkg::MODE_READY;
                  led_on           = 1'b0;
               end else begin
                  r.release_select = wait_expired();
               end
            end
            sfl_pkg::MODE_COMM_ERR: begin
               if (retry_cnt < link_cfg.retry_limit) begin
                  if (wait_cnt >= link_cfg.wait_limit) begin
                     pin_run   = 1'b0;
                     retry_cnt = retry_cnt + 8'd1;
                     lnk_mode  = sfl_pkg::MODE_UNINIT;
                     wait_cnt  = 8'd0;
                  end else begin
                     wait_cnt = wait_cnt + 8'd1;
                  end
               end else begin
                  lnk_mode = sfl_pkg::MODE_DEV_ERR;
               end
            end
            default: begin
            end
         endcase
         r.reply = lnk_mode;
      end else begin
         r.reply = lnk_mode;
         if (lnk_mode == sfl_pkg::MODE_READY) begin
            span = 32'(it.address) + 32'(it.byte_count);
            if (span < 32'(link_cfg.flash_bytes) && it.byte_count != 16'd0 &&
                it.byte_count <= 16'(sfl_pkg::MAX_READ)) begin
               led_on = 1'b1;
               if (it.cs_granted) begin
                  r.start_transfer = 1'b1;
                  r.opcode         = sfl_pkg::OP_READ;
                  r.xfer_address   = it.address;
                  r.rx_length      = it.byte_count[8:0] + sfl_pkg::RD_RX_EXTRA;
                  wait_cnt = (link_cfg.wait_limit != 8'd0) ?
                             link_cfg.wait_limit - 8'd1 : 8'd0;
                  lnk_mode = sfl_pkg::MODE_BUSY;
               end else begin
                  lnk_mode = sfl_pkg::MODE_COMM_ERR;
                  r.reply  = sfl_pkg::MODE_COMM_ERR;
               end
            end else begin
               r.reply = sfl_pkg::REPLY_PARAM_ERR;
            end
         end
      end
      r.mode         = lnk_mode;
      r.reset_pin    = pin_run;
      r.activity_led = led_on;
      return r;
   endfunction

   function automatic sfl_pkg::item_type tick_item(input logic done, input logic cs,
                                                   input logic [23:0] id);
      sfl_pkg::item_type it;
      it            = '0;
      it.action     = sfl_pkg::ACT_TICK;
      it.xfer_done  = done;
      it.cs_granted = cs;
      it.id_bytes   = id;
      return it;
   endfunction

   function automatic sfl_pkg::item_type read_item(input logic [23:0] addr,
                                                   input logic [15:0] cnt,
                                                   input logic cs);
      sfl_pkg::item_type it;
      it            = '0;
      it.action     = sfl_pkg::ACT_READ;
      it.cs_granted = cs;
      it.address    = addr;
      it.byte_count = cnt;
      return it;
   endfunction

   function automatic plan_row_type item_row(input sfl_pkg::item_type s);
      return '{ROW_ITEM, s, 1'b0, '0, '0, '0};
   endfunction

   function automatic plan_row_type check_row(input sfl_pkg::item_type s,
                                              input sfl_pkg::result_type w);
      return '{ROW_ITEM, s, 1'b1, w, '0, '0};
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input logic [24:0] val);
      return '{ROW_CSR, '0, 1'b0, '0, idx, val};
   endfunction

   // random item, shaped by the model state so most traffic gets past bring-up
   function automatic sfl_pkg::item_type draw_item();
      sfl_pkg::item_type it;
      logic [24:0]       room;
      it.action     = ($urandom_range(0, 99) < 40) ? sfl_pkg::ACT_READ : sfl_pkg::ACT_TICK;
      it.xfer_done  = ($urandom_range(0, 99) < 55);
      it.cs_granted = ($urandom_range(0, 99) < 92);
      it.id_bytes   = ($urandom_range(0, 99) < 85) ? link_cfg.expected_id : 24'($urandom);
      it.address    = 24'($urandom);
      if ($urandom_range(0, 99) < 80) begin
         // well-formed read, sometimes right at the end of the flash
         it.byte_count = 16'($urandom_range(1, sfl_pkg::MAX_READ));
         if (link_cfg.flash_bytes > 25'(it.byte_count)) begin
            room = link_cfg.flash_bytes - 25'(it.byte_count);
            case ($urandom_range(0, 9))
               0:       it.address = 24'(room - 25'd1);
               1:       it.address = 24'(room);
               default: it.address = 24'($urandom_range(0, room - 25'd1));
            endcase
         end
      end else begin
         case ($urandom_range(0, 2))
            0:       it.byte_count = 16'd0;
            1:       it.byte_count = 16'(sfl_pkg::MAX_READ + 1);
            default: it.byte_count = 16'($urandom);
         endcase
      end
      return it;
   endfunction

   function automatic void match_field(input string fld, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fld, want, got);
         error_count++;
      end
   endfunction

   // offer one item after a random gap and log its expected result on accept
   task automatic offer_item(input sfl_pkg::item_type it, input logic typed,
                             input sfl_pkg::result_type want);
      int                  gap;
      sfl_pkg::result_type calc;
      gap = (burst_on || (sent_count % 100) < 15) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= it.action;
      req_xfer_done  <= it.xfer_done;
      req_cs_granted <= it.cs_granted;
      req_id_bytes   <= it.id_bytes;
      req_address    <= it.address;
      req_byte_count <= it.byte_count;
      do @(posedge clock); while (!req_ready);
      calc = link_step(it);
      due_results.push_back(typed ? want : calc);
      sent_count++;
   endtask

   // let every outstanding item come back, then idle with req_valid low
   task automatic settle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write; caller drops csr_we after the last write
   task automatic write_csr(input logic [1:0] idx, input logic [24:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         sfl_pkg::CSR_WAIT_LIMIT:  link_cfg.wait_limit  = val[7:0];
         sfl_pkg::CSR_RETRY_LIMIT: link_cfg.retry_limit = val[7:0];
         sfl_pkg::CSR_EXPECTED_ID: link_cfg.expected_id = val[23:0];
         sfl_pkg::CSR_FLASH_BYTES: link_cfg.flash_bytes = val;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      plan_row_type plan[$];
      logic [7:0]   lim_wait;
      logic [7:0]   lim_retry;
      logic [23:0]  id_cfg;
      logic [24:0]  size_cfg;
      int           n_items;

      link_cfg.wait_limit  = sfl_pkg::WAIT_LIMIT_RST;
      link_cfg.retry_limit = sfl_pkg::RETRY_LIMIT_RST;
      link_cfg.expected_id = sfl_pkg::EXPECTED_ID_RST;
      link_cfg.flash_bytes = sfl_pkg::FLASH_BYTES_RST;
      lnk_mode  = sfl_pkg::MODE_UNINIT;
      wait_cnt  = 8'd0;
      retry_cnt = 8'd0;
      pin_run   = 1'b0;
      led_on    = 1'b0;

      // result fields: mode, reply, start, opcode, address, rx length,
      // release, reset pin, led, read done
      // read before bring-up is ignored
      plan.push_back(check_row(read_item(24'h0, 16'd1, 1'b1),
         '{sfl_pkg::MODE_UNINIT, sfl_pkg::MODE_UNINIT, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b0, 1'b0, 1'b0}));
      // id read issued
      plan.push_back(check_row(tick_item(1'b0, 1'b1, 24'h0),
         '{sfl_pkg::MODE_INIT, sfl_pkg::MODE_INIT, 1'b1, sfl_pkg::OP_READ_ID, 24'h0,
           sfl_pkg::ID_RX_LEN, 1'b0, 1'b1, 1'b1, 1'b0}));
      // id matches
      plan.push_back(check_row(tick_item(1'b1, 1'b1, sfl_pkg::EXPECTED_ID_RST),
         '{sfl_pkg::MODE_READY, sfl_pkg::MODE_READY, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b1, 1'b1, 1'b0, 1'b0}));
      // bad read parameters: zero count, huge count, end of flash reached
      plan.push_back(check_row(read_item(24'h0, 16'd0, 1'b1),
         '{sfl_pkg::MODE_READY, sfl_pkg::REPLY_PARAM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b0, 1'b0}));
      plan.push_back(check_row(read_item(24'h0, 16'hFFFF, 1'b1),
         '{sfl_pkg::MODE_READY, sfl_pkg::REPLY_PARAM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b0, 1'b0}));
      plan.push_back(check_row(read_item(24'hFFFF00, 16'd256, 1'b1),
         '{sfl_pkg::MODE_READY, sfl_pkg::REPLY_PARAM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b0, 1'b0}));
      // largest read the range check accepts at the top of the flash
      plan.push_back(check_row(read_item(24'hFFFEFF, 16'd256, 1'b1),
         '{sfl_pkg::MODE_BUSY, sfl_pkg::MODE_READY, 1'b1, sfl_pkg::OP_READ, 24'hFFFEFF,
           9'd260, 1'b0, 1'b1, 1'b1, 1'b0}));
      // request while busy only reports the mode
      plan.push_back(check_row(read_item(24'h0, 16'd1, 1'b1),
         '{sfl_pkg::MODE_BUSY, sfl_pkg::MODE_BUSY, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b1, 1'b0}));
      // stalled read expires on the second tick
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(check_row(tick_item(1'b0, 1'b1, 24'h0),
         '{sfl_pkg::MODE_COMM_ERR, sfl_pkg::MODE_COMM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b1, 1'b1, 1'b1, 1'b0}));
      // wait count kept, so the retry follows at once
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      // select refused on id read
      plan.push_back(check_row(tick_item(1'b0, 1'b0, 24'h0),
         '{sfl_pkg::MODE_COMM_ERR, sfl_pkg::MODE_COMM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b1, 1'b0}));
      // zero wait limit: every wait expires at once
      plan.push_back(csr_row(sfl_pkg::CSR_WAIT_LIMIT, 25'd0));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      // upper extremes
      plan.push_back(csr_row(sfl_pkg::CSR_WAIT_LIMIT, 25'd255));
      plan.push_back(csr_row(sfl_pkg::CSR_EXPECTED_ID, 25'hFFFFFF));
      plan.push_back(csr_row(sfl_pkg::CSR_RETRY_LIMIT, 25'd255));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b1, 1'b1, 24'hFFFFFF)));
      // one-byte flash rejects every read
      plan.push_back(csr_row(sfl_pkg::CSR_FLASH_BYTES, 25'd1));
      plan.push_back(check_row(read_item(24'h0, 16'd1, 1'b1),
         '{sfl_pkg::MODE_READY, sfl_pkg::REPLY_PARAM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b0, 1'b0}));
      // select refused on read
      plan.push_back(csr_row(sfl_pkg::CSR_FLASH_BYTES, sfl_pkg::FLASH_BYTES_RST));
      plan.push_back(csr_row(sfl_pkg::CSR_EXPECTED_ID, 25'd0));
      plan.push_back(check_row(read_item(24'h0, 16'd1, 1'b0),
         '{sfl_pkg::MODE_COMM_ERR, sfl_pkg::MODE_COMM_ERR, 1'b0, 8'h0, 24'h0, 9'd0,
           1'b0, 1'b1, 1'b1, 1'b0}));
      // recover with the smallest nonzero wait limit and finish a read
      plan.push_back(csr_row(sfl_pkg::CSR_WAIT_LIMIT, 25'd1));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b0, 1'b1, 24'h0)));
      plan.push_back(item_row(tick_item(1'b1, 1'b1, 24'h0)));
      plan.push_back(item_row(read_item(24'hFFFFFE, 16'd1, 1'b1)));
      plan.push_back(item_row(tick_item(1'b1, 1'b1, 24'h0)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_csr(plan[i].reg_index, plan[i].reg_value);
            csr_we <= 1'b0;
         end else begin
            offer_item(plan[i].stim, plan[i].typed, plan[i].want);
         end
      end

      // random phases, each on a fresh register setting
      for (int ph = 0; ph < 5; ph++) begin
         settle();
         case (ph)
            0: begin
               lim_wait = 8'd3;   lim_retry = 8'd255; id_cfg = 24'($urandom);
               size_cfg = sfl_pkg::FLASH_BYTES_RST; n_items = 150;
            end
            1: begin
               lim_wait = 8'd1;   lim_retry = 8'd255; id_cfg = sfl_pkg::EXPECTED_ID_RST;
               size_cfg = 25'h0001000; n_items = 120;
            end
            2: begin
               lim_wait = 8'd255; lim_retry = 8'd255; id_cfg = 24'($urandom);
               size_cfg = sfl_pkg::FLASH_BYTES_RST; n_items = 80;
            end
            3: begin
               lim_wait = 8'd6;   lim_retry = 8'd200; id_cfg = 24'($urandom);
               size_cfg = 25'($urandom_range(1, 1 << 24)); n_items = 150;
            end
            default: begin
               // no retries left: the next comm error locks the device
               lim_wait = 8'd2;   lim_retry = 8'd0;   id_cfg = 24'($urandom);
               size_cfg = sfl_pkg::FLASH_BYTES_RST; n_items = 30;
            end
         endcase
         write_csr(sfl_pkg::CSR_WAIT_LIMIT, 25'(lim_wait));
         write_csr(sfl_pkg::CSR_RETRY_LIMIT, 25'(lim_retry));
         write_csr(sfl_pkg::CSR_EXPECTED_ID, 25'(id_cfg));
         write_csr(sfl_pkg::CSR_FLASH_BYTES, size_cfg);
         csr_we <= 1'b0;
         // back-to-back offers while the receiver holds off
         burst_on = (ph == 1);
         repeat (n_items) offer_item(draw_item(), 1'b0, '0);
         burst_on = 1'b0;
      end

      settle();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off, field checks
   initial begin : results
      int                  stall;
      sfl_pkg::result_type want;
      while (reset) @(posedge clock);
      forever begin
         if (burst_on && !held_off) begin
            stall    = 60;
            held_off = 1'b1;
         end else begin
            stall = ((seen_count % 100) < 20) ? 0 : $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         seen_count++;
         if (due_results.size() == 0) begin
            $display("%0t: result item with nothing expected, mode 0x%0h reply 0x%0h",
                     $time, rsp_mode, rsp_reply);
            error_count++;
         end else begin
            want = due_results.pop_front();
            match_field("mode", want.mode, rsp_mode);
            match_field("reply", want.reply, rsp_reply);
            match_field("start_transfer", want.start_transfer, rsp_start_transfer);
            match_field("opcode", want.opcode, rsp_opcode);
            match_field("xfer_address", want.xfer_address, rsp_xfer_address);
            match_field("rx_length", want.rx_length, rsp_rx_length);
            match_field("release_select", want.release_select, rsp_release_select);
            match_field("reset_pin", want.reset_pin, rsp_reset_pin);
            match_field("activity_led", want.activity_led, rsp_activity_led);
            match_field("read_done", want.read_done, rsp_read_done);
         end
      end
   end

   // hang guard
   initial begin : watchdog
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
